// ----- design/sht_pkg.sv -----
// Shared types and constants for the session handle table.
`timescale 1ns / 1ps

package sht_pkg;

    localparam int SLOT_COUNT_DEF = 16;
    localparam int ID_W           = 32;
    localparam int HANDLE_W       = 5;

    typedef enum logic [1:0] {
        OP_OPEN       = 2'd0,
        OP_CLOSE      = 2'd1,
        OP_INFO       = 2'd2,
        OP_INVALIDATE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_INVALID    = 2'd1,
        ST_NO_SPACE   = 2'd2,
        ST_BAD_HANDLE = 2'd3
    } status_t;

    // One request as it travels along the slot chain, with its result so far.
    typedef struct packed {
        op_t                 kind;
        logic [ID_W-1:0]     owner_id;
        logic [ID_W-1:0]     provider_id;
        logic [ID_W-1:0]     service_index;
        logic [HANDLE_W-1:0] handle;
        logic                done;
        status_t             status;
        logic [HANDLE_W-1:0] handle_out;
        logic [ID_W-1:0]     owner_out;
        logic [ID_W-1:0]     provider_out;
        logic [ID_W-1:0]     service_out;
        logic [HANDLE_W-1:0] closed_count;
    } req_t;

endpackage

// ----- design/sht_cell.sv -----
// One slot of the session table, acting on each request as it passes by.
`timescale 1ns / 1ps

module sht_cell
    import sht_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic advance,
    input  logic valid_in,
    input  req_t req_in,
    output logic valid_out,
    output req_t req_out
);

    logic            active_reg, active_next;
    logic [ID_W-1:0] owner_reg, owner_next;
    logic [ID_W-1:0] provider_reg, provider_next;
    logic [ID_W-1:0] service_reg, service_next;
    logic            valid_reg;
    req_t            req_reg, req_next;
    logic            handle_hit;

    assign handle_hit = active_reg && (32'(req_in.handle) == 32'(IDX + 1));

    always_comb begin
        active_next   = active_reg;
        owner_next    = owner_reg;
        provider_next = provider_reg;
        service_next  = service_reg;
        req_next      = req_in;
        if (valid_in && !req_in.done) begin
            unique case (req_in.kind)
                OP_OPEN: begin
                    if (!active_reg) begin
                        active_next         = 1'b1;
                        owner_next          = req_in.owner_id;
                        provider_next       = req_in.provider_id;
                        service_next        = req_in.service_index;
                        req_next.handle_out = HANDLE_W'(IDX + 1);
                        req_next.status     = ST_OK;
                        req_next.done       = 1'b1;
                    end
                end
                OP_CLOSE: begin
                    if (handle_hit) begin
                        active_next     = 1'b0;
                        owner_next      = '0;
                        provider_next   = '0;
                        service_next    = '0;
                        req_next.status = ST_OK;
                        req_next.done   = 1'b1;
                    end
                end
                OP_INFO: begin
                    if (handle_hit) begin
                        req_next.handle_out   = req_in.handle;
                        req_next.owner_out    = owner_reg;
                        req_next.provider_out = provider_reg;
                        req_next.service_out  = service_reg;
                        req_next.status       = ST_OK;
                        req_next.done         = 1'b1;
                    end
                end
                OP_INVALIDATE: begin
                    // Invalidate never finishes early: every slot must see it.
                    if (active_reg && provider_reg == req_in.provider_id) begin
                        active_next           = 1'b0;
                        owner_next            = '0;
                        provider_next         = '0;
                        service_next          = '0;
                        req_next.closed_count = req_in.closed_count + HANDLE_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            owner_reg    <= '0;
            provider_reg <= '0;
            service_reg  <= '0;
            valid_reg    <= 1'b0;
        end else if (advance) begin
            active_reg   <= active_next;
            owner_reg    <= owner_next;
            provider_reg <= provider_next;
            service_reg  <= service_next;
            valid_reg    <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            req_reg <= req_next;
        end
    end

    assign valid_out = valid_reg;
    assign req_out   = req_reg;

endmodule

// ----- design/session_handle_table_top.sv -----
// Top level of the session handle table: request entry, slot chain and result register.
`timescale 1ns / 1ps

// Session handle table. Requests (open, close, info, invalidate provider) come in on
// the s_ channel and each one yields exactly one result on the m_ channel, in order.
// A request enters the first slot cell when s_valid and s_ready are both high, then
// moves one cell per cycle while the chain advances, down a chain of SLOT_COUNT cells,
// each of which holds one slot and acts on the request as it passes. After the last
// cell the result lands in the output register, which drives m_valid. The chain is
// fully pipelined: while it is not stalled, one request per cycle is taken, since
// each cell touches only its own slot and requests reach every cell in order.
// Open takes the lowest free slot because the first free cell on the way claims it;
// invalidate visits all cells and counts the slots it frees.
// When the receiver holds m_ready low, the chain keeps moving until a result reaches
// the last cell while another waits in the output register; only then does it stop
// and drop s_ready, so requests are still taken while one finished result waits there.
// Reset (aresetn low, synchronous) frees every slot, clears stored fields and drops
// all requests in flight.

module session_handle_table_top
    import sht_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_kind,
    input  logic [ID_W-1:0]     s_owner_id,
    input  logic [ID_W-1:0]     s_provider_id,
    input  logic [ID_W-1:0]     s_service_index,
    input  logic [HANDLE_W-1:0] s_handle,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic [HANDLE_W-1:0] m_handle_out,
    output logic [ID_W-1:0]     m_owner_out,
    output logic [ID_W-1:0]     m_provider_out,
    output logic [ID_W-1:0]     m_service_out,
    output logic [HANDLE_W-1:0] m_closed_count
);

    req_t chain_req [0:SLOT_COUNT];
    logic chain_vld [0:SLOT_COUNT];
    req_t entry_req;
    logic advance;
    logic last_vld;
    logic m_valid_reg, m_valid_next;
    req_t m_req_reg;

    assign last_vld = chain_vld[SLOT_COUNT];
    assign advance  = !(last_vld && m_valid_reg && !m_ready);
    assign s_ready  = advance;

    // Argument checks are settled before the request enters the chain.
    always_comb begin
        entry_req               = '0;
        entry_req.kind          = op_t'(s_kind);
        entry_req.owner_id      = s_owner_id;
        entry_req.provider_id   = s_provider_id;
        entry_req.service_index = s_service_index;
        entry_req.handle        = s_handle;
        unique case (op_t'(s_kind))
            OP_OPEN: begin
                if (s_owner_id == '0 || s_provider_id == '0) begin
                    entry_req.status = ST_INVALID;
                    entry_req.done   = 1'b1;
                end else begin
                    entry_req.status = ST_NO_SPACE;
                end
            end
            OP_CLOSE, OP_INFO: begin
                if (s_handle == '0) begin
                    entry_req.status = ST_INVALID;
                    entry_req.done   = 1'b1;
                end else begin
                    entry_req.status = ST_BAD_HANDLE;
                end
            end
            OP_INVALIDATE: begin
                if (s_provider_id == '0) begin
                    entry_req.status = ST_INVALID;
                    entry_req.done   = 1'b1;
                end else begin
                    entry_req.status = ST_OK;
                end
            end
            default: ;
        endcase
    end

    assign chain_req[0] = entry_req;
    assign chain_vld[0] = s_valid;

    for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_slot
        sht_cell #(
            .IDX(i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .valid_in (chain_vld[i]),
            .req_in   (chain_req[i]),
            .valid_out(chain_vld[i+1]),
            .req_out  (chain_req[i+1])
        );
    end

    always_comb begin
        if (last_vld && advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (last_vld && advance) begin
            m_req_reg <= chain_req[SLOT_COUNT];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_req_reg.status;
    assign m_handle_out   = m_req_reg.handle_out;
    assign m_owner_out    = m_req_reg.owner_out;
    assign m_provider_out = m_req_reg.provider_out;
    assign m_service_out  = m_req_reg.service_out;
    assign m_closed_count = m_req_reg.closed_count;

endmodule

// ----- test/sht_checker.sv -----
// Scoreboard for the session handle table: predicts every request's result and checks it.
`timescale 1ns / 1ps

module sht_checker
    import sht_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [1:0]          s_kind,
    input  logic [ID_W-1:0]     s_owner_id,
    input  logic [ID_W-1:0]     s_provider_id,
    input  logic [ID_W-1:0]     s_service_index,
    input  logic [HANDLE_W-1:0] s_handle,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [1:0]          m_status,
    input  logic [HANDLE_W-1:0] m_handle_out,
    input  logic [ID_W-1:0]     m_owner_out,
    input  logic [ID_W-1:0]     m_provider_out,
    input  logic [ID_W-1:0]     m_service_out,
    input  logic [HANDLE_W-1:0] m_closed_count,
    output int                  error_count,
    output int                  outstanding,
    output int                  request_count,
    output int                  result_count,
    output int                  full_refusals,
    output int                  multi_frees
);

    localparam int SLOTS = SLOT_COUNT_DEF;

    typedef struct packed {
        status_t             status;
        logic [HANDLE_W-1:0] handle_out;
        logic [ID_W-1:0]     owner_out;
        logic [ID_W-1:0]     provider_out;
        logic [ID_W-1:0]     service_out;
        logic [HANDLE_W-1:0] closed_count;
    } reply_t;

    logic            slot_used     [SLOTS];
    logic [ID_W-1:0] slot_owner    [SLOTS];
    logic [ID_W-1:0] slot_provider [SLOTS];
    logic [ID_W-1:0] slot_service  [SLOTS];

    reply_t expected_replies[$];

    function automatic void release_slot(int i);
        slot_used[i]     = 1'b0;
        slot_owner[i]    = '0;
        slot_provider[i] = '0;
        slot_service[i]  = '0;
    endfunction

    // Applies one request to the shadow table and returns the result it must produce.
    function automatic reply_t apply_request(op_t op, logic [ID_W-1:0] owner,
                                             logic [ID_W-1:0] prov, logic [ID_W-1:0] svc,
                                             logic [HANDLE_W-1:0] h);
        reply_t r;
        int     hi;
        int     freed;
        r      = '0;
        r.status = ST_OK;
        hi     = int'(h);
        freed  = 0;
        case (op)
            OP_OPEN: begin
                if (owner == '0 || prov == '0) begin
                    r.status = ST_INVALID;
                end else begin
                    r.status = ST_NO_SPACE;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!slot_used[i] && r.status == ST_NO_SPACE) begin
                            slot_used[i]     = 1'b1;
                            slot_owner[i]    = owner;
                            slot_provider[i] = prov;
                            slot_service[i]  = svc;
                            r.handle_out     = HANDLE_W'(i + 1);
                            r.status         = ST_OK;
                        end
                    end
                end
            end
            OP_CLOSE, OP_INFO: begin
                if (hi == 0) begin
                    r.status = ST_INVALID;
                end else if (hi > SLOTS || !slot_used[hi-1]) begin
                    r.status = ST_BAD_HANDLE;
                end else if (op == OP_CLOSE) begin
                    release_slot(hi - 1);
                end else begin
                    r.handle_out   = h;
                    r.owner_out    = slot_owner[hi-1];
                    r.provider_out = slot_provider[hi-1];
                    r.service_out  = slot_service[hi-1];
                end
            end
            default: begin
                if (prov == '0) begin
                    r.status = ST_INVALID;
                end else begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_used[i] && slot_provider[i] == prov) begin
                            release_slot(i);
                            freed++;
                        end
                    end
                    r.closed_count = HANDLE_W'(freed);
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        reply_t want;
        reply_t got;
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                release_slot(i);
            end
            expected_replies.delete();
            error_count   <= 0;
            outstanding   <= 0;
            request_count <= 0;
            result_count  <= 0;
            full_refusals <= 0;
            multi_frees   <= 0;
        end else begin
            if (s_valid && s_ready) begin
                want = apply_request(op_t'(s_kind), s_owner_id, s_provider_id,
                                     s_service_index, s_handle);
                expected_replies.push_back(want);
                request_count <= request_count + 1;
                if (want.status == ST_NO_SPACE) begin
                    full_refusals <= full_refusals + 1;
                end
                if (want.closed_count > 1) begin
                    multi_frees <= multi_frees + 1;
                end
            end
            if (m_valid && m_ready) begin
                got.status       = status_t'(m_status);
                got.handle_out   = m_handle_out;
                got.owner_out    = m_owner_out;
                got.provider_out = m_provider_out;
                got.service_out  = m_service_out;
                got.closed_count = m_closed_count;
                result_count <= result_count + 1;
                if (expected_replies.size() == 0) begin
                    error_count <= error_count + 1;
                    if (error_count < 10) begin
                        $display("%0t: result with no request waiting: status %0d handle %0d",
                                 $time, m_status, m_handle_out);
                    end
                end else begin
                    want = expected_replies.pop_front();
                    if (got.status !== want.status || got.handle_out !== want.handle_out ||
                        got.owner_out !== want.owner_out ||
                        got.provider_out !== want.provider_out ||
                        got.service_out !== want.service_out ||
                        got.closed_count !== want.closed_count) begin
                        error_count <= error_count + 1;
                        if (error_count < 10) begin
                            $display("%0t: mismatch, expected status %0d handle %0d owner %h",
                                     $time, want.status, want.handle_out, want.owner_out);
                            $display("    provider %h service %h freed %0d",
                                     want.provider_out, want.service_out, want.closed_count);
                            $display("  got status %0d handle %0d owner %h provider %h",
                                     m_status, m_handle_out, m_owner_out, m_provider_out);
                            $display("    service %h freed %0d", m_service_out, m_closed_count);
                        end
                    end
                end
            end
            outstanding <= expected_replies.size();
        end
    end

endmodule

// ----- test/tb.sv -----
// Testbench top for the session handle table: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
    import sht_pkg::*;

    localparam int RANDOM_REQUESTS = 1250;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 40;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [1:0]          s_kind;
    logic [ID_W-1:0]     s_owner_id;
    logic [ID_W-1:0]     s_provider_id;
    logic [ID_W-1:0]     s_service_index;
    logic [HANDLE_W-1:0] s_handle;
    logic                m_valid;
    logic                m_ready;
    logic [1:0]          m_status;
    logic [HANDLE_W-1:0] m_handle_out;
    logic [ID_W-1:0]     m_owner_out;
    logic [ID_W-1:0]     m_provider_out;
    logic [ID_W-1:0]     m_service_out;
    logic [HANDLE_W-1:0] m_closed_count;

    int error_count;
    int outstanding;
    int request_count;
    int result_count;
    int full_refusals;
    int multi_frees;
    int idle_cycles;

    // A few providers are reused so that invalidates hit several sessions at once.
    logic [ID_W-1:0] provider_pool [4] = '{32'h0000_0001, 32'h8000_0000,
                                            32'h1234_5678, 32'hFFFF_FFFF};

    session_handle_table_top i_dut (.*);

    sht_checker i_checker (.*);

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    function automatic logic [ID_W-1:0] pick_owner();
        return ($urandom_range(0, 19) == 0) ? '0 : ID_W'($urandom);
    endfunction

    function automatic logic [ID_W-1:0] pick_provider();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            return '0;
        end else if (r < 80) begin
            return provider_pool[$urandom_range(0, 3)];
        end
        return ID_W'($urandom);
    endfunction

    function automatic logic [HANDLE_W-1:0] pick_handle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            return '0;
        end else if (r < 88) begin
            return HANDLE_W'($urandom_range(1, SLOT_COUNT_DEF));
        end
        return HANDLE_W'($urandom_range(SLOT_COUNT_DEF + 1, 31));
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Presents one request after the given number of idle cycles and waits for its acceptance.
    task automatic send_request(int gap, op_t op, logic [ID_W-1:0] owner,
                                logic [ID_W-1:0] prov, logic [ID_W-1:0] svc,
                                logic [HANDLE_W-1:0] h);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid         <= 1'b1;
        s_kind          <= op;
        s_owner_id      <= owner;
        s_provider_id   <= prov;
        s_service_index <= svc;
        s_handle        <= h;
        do @(posedge aclk); while (!s_ready);
    endtask

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_kind          = OP_OPEN;
        s_owner_id      = '0;
        s_provider_id   = '0;
        s_service_index = '0;
        s_handle        = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    // Receiver: runs of ready broken by stalls, mostly short, now and then long.
    initial begin
        int high_len;
        int stall_len;
        int r;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            high_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 300)
                                                    : $urandom_range(1, 12);
            r         = $urandom_range(0, 99);
            stall_len = (r < 70) ? $urandom_range(1, 3) :
                        (r < 90) ? $urandom_range(4, 10) : $urandom_range(20, 60);
            @(negedge aclk);
            m_ready <= 1'b1;
            repeat (high_len - 1) @(negedge aclk);
            @(negedge aclk);
            m_ready <= 1'b0;
            repeat (stall_len - 1) @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            idle_cycles <= 0;
        end else if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired: no request or result moved for %0d cycles",
                         WATCHDOG_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        int              r;
        int              gap;
        int              burst_left;
        op_t             op;
        logic [ID_W-1:0] prov;
        @(posedge aresetn);

        // Directed part: bad pids, fill the table, overflow, handle edges, invalidates.
        send_request(0, OP_OPEN, '0, 32'h5, 32'h7, 5'd3);
        send_request(1, OP_OPEN, 32'h5, '0, 32'h7, 5'd0);
        for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
            send_request(0, OP_OPEN, (i == 0) ? 32'hFFFF_FFFF : ID_W'(100 + i),
                         (i % 2 == 0) ? 32'hFFFF_FFFF : 32'h0000_0001,
                         (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : ID_W'($urandom),
                         HANDLE_W'(i));
        end
        send_request(0, OP_OPEN, 32'h1, 32'h2, 32'h3, 5'd31);
        send_request(2, OP_INFO, '0, '0, '0, 5'd16);
        send_request(0, OP_INFO, '0, '0, '0, 5'd1);
        send_request(0, OP_INFO, '0, '0, '0, 5'd0);
        send_request(0, OP_CLOSE, '0, '0, '0, 5'd17);
        send_request(0, OP_INFO, '0, '0, '0, 5'd31);
        send_request(0, OP_INVALIDATE, '0, '0, '0, 5'd0);
        send_request(0, OP_INVALIDATE, '0, 32'hFFFF_FFFF, '0, 5'd0);
        send_request(0, OP_INVALIDATE, '0, 32'hFFFF_FFFF, '0, 5'd0);
        send_request(3, OP_CLOSE, '0, '0, '0, 5'd2);
        send_request(0, OP_CLOSE, '0, '0, '0, 5'd2);

        // Random part: mostly meaningful operations on a small set of providers.
        burst_left = 0;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (burst_left == 0 && $urandom_range(0, 19) == 0) begin
                burst_left = $urandom_range(30, 120);
            end
            if (burst_left > 0) begin
                burst_left--;
                gap = 0;
            end else begin
                gap = pick_gap();
            end
            r    = $urandom_range(0, 99);
            op   = (r < 45) ? OP_OPEN : (r < 63) ? OP_CLOSE : (r < 88) ? OP_INFO
                                                                         : OP_INVALIDATE;
            prov = pick_provider();
            if (op == OP_CLOSE || op == OP_INFO) begin
                send_request(gap, op, ID_W'($urandom), prov, ID_W'($urandom), pick_handle());
            end else begin
                send_request(gap, op, pick_owner(), prov, ID_W'($urandom),
                             HANDLE_W'($urandom_range(0, 31)));
            end
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d requests and %0d results, with %0d opens refused on a full",
                 request_count, result_count, full_refusals);
        $display("table and %0d invalidates freeing several sessions; %0d failures.",
                 multi_frees, error_count + outstanding);
        if (error_count == 0 && outstanding == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
